// ===== hw/rtl/qdd_pkg.sv =====
package qdd_pkg;

  // Detent event code carried on the result stream; the same coding names the
  // direction of a single Gray-code step.
  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_CW   = 2'd1,
    DIR_CCW  = 2'd2
  } dir_t;

  // Decoder state: last phase seen and the signed step accumulator.
  typedef struct packed {
    logic [1:0]        phase;
    logic signed [7:0] total;
  } qdd_state_t;

  localparam int unsigned TRIG_W = 7;
  localparam logic [TRIG_W-1:0] TRIGGER_DEFAULT = 7'd4;

  // Transition codes, {previous phase, current phase}.
  localparam logic [3:0] TR_3_TO_1 = 4'hD;
  localparam logic [3:0] TR_1_TO_0 = 4'h4;
  localparam logic [3:0] TR_0_TO_2 = 4'h2;
  localparam logic [3:0] TR_2_TO_3 = 4'hB;
  localparam logic [3:0] TR_3_TO_2 = 4'hE;
  localparam logic [3:0] TR_2_TO_0 = 4'h8;
  localparam logic [3:0] TR_0_TO_1 = 4'h1;
  localparam logic [3:0] TR_1_TO_3 = 4'h7;

  function automatic dir_t step_kind(input logic [3:0] code);
    dir_t kind;
    unique case (code) inside
      TR_3_TO_1, TR_1_TO_0, TR_0_TO_2, TR_2_TO_3: kind = DIR_CW;
      TR_3_TO_2, TR_2_TO_0, TR_0_TO_1, TR_1_TO_3: kind = DIR_CCW;
      default:                                    kind = DIR_NONE;
    endcase
    return kind;
  endfunction

endpackage

// ===== hw/rtl/qdd_step.sv =====
// Next-state and event logic for one encoder sample.
module qdd_step (
  input  logic                          func,
  input  logic [1:0]                    phase,
  input  logic [qdd_pkg::TRIG_W-1:0]    trigger_count,
  input  qdd_pkg::qdd_state_t           state,
  output qdd_pkg::qdd_state_t           state_next,
  output qdd_pkg::dir_t                 direction
);

  always_comb begin
    qdd_pkg::dir_t              kind;
    logic [qdd_pkg::TRIG_W-1:0] trig;
    logic signed [7:0]          base;
    logic signed [7:0]          sum;
    logic [7:0]                 mag;

    kind = qdd_pkg::step_kind({state.phase, phase});
    trig = (trigger_count == '0) ? qdd_pkg::TRIGGER_DEFAULT : trigger_count;
    base = state.total;
    sum  = state.total;

    // A reversal drops whatever was gathered in the old direction first.
    case (kind)
      qdd_pkg::DIR_CW: begin
        base = state.total[7] ? 8'sd0 : state.total;
        sum  = base + 8'sd1;
      end
      qdd_pkg::DIR_CCW: begin
        base = (state.total > 8'sd0) ? 8'sd0 : state.total;
        sum  = base - 8'sd1;
      end
      default: begin
        sum = 8'sd0;
      end
    endcase
    mag = sum[7] ? 8'(-sum) : 8'(sum);

    state_next = state;
    direction  = qdd_pkg::DIR_NONE;
    if (func) begin
      state_next.phase = phase;
      state_next.total = 8'sd0;
    end else if (phase != state.phase) begin
      state_next.phase = phase;
      if (kind == qdd_pkg::DIR_NONE) begin
        state_next.total = 8'sd0;
      end else if (mag >= {1'b0, trig}) begin
        direction        = kind;
        state_next.total = 8'sd0;
      end else begin
        state_next.total = sum;
      end
    end
  end

endmodule

// ===== hw/rtl/quadrature_detent_decoder.sv =====
// Quadrature detent decoder. Each input word is one sample of encoder lines A
// and B (s_tdata bit 0 is A, bit 1 is B); s_tuser high marks a resync word that
// loads the current lines as the phase and clears the step accumulator. Every
// input word yields exactly one output word whose low two bits give the detent
// event: 0 none, 1 clockwise, 2 counter-clockwise. Valid Gray-code steps are
// counted in a signed accumulator that restarts on a change of direction and
// on a double transition; an event fires and clears the accumulator once its
// magnitude reaches trigger_count, where zero stands for four (reset value 4).
// The block takes one word per clock while m_tready stays high: a sample passes
// an input register, combinational decode logic that also updates the phase and
// accumulator, and an output register, which presents the result on m_tvalid.
// trigger_count may only be written while no word is in flight.
module quadrature_detent_decoder (
  input  logic       clk,
  input  logic       rst,

  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [0] line_a, [1] line_b, [7:2] zero
  input  logic       s_tuser,   // [0] func (resync)

  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [1:0] direction, [7:2] zero

  input  logic       cfg_we,
  input  logic [6:0] cfg_data
);

  logic [qdd_pkg::TRIG_W-1:0] trigger_count;

  // Input register.
  logic       in_valid;
  logic       in_func;
  logic [1:0] in_phase;

  // Decoder state.
  qdd_pkg::qdd_state_t state;
  qdd_pkg::qdd_state_t state_next;
  qdd_pkg::dir_t       dir_next;

  // Output register.
  logic          out_valid;
  qdd_pkg::dir_t out_dir;

  logic advance;

  // A word moves from the input register to the output register whenever the
  // output register is empty or being drained in this same cycle.
  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      trigger_count <= qdd_pkg::TRIGGER_DEFAULT;
    end else if (cfg_we) begin
      trigger_count <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  // Phase is {A, B}.
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_func  <= s_tuser;
      in_phase <= {s_tdata[0], s_tdata[1]};
    end
  end

  qdd_step u_step (
    .func          (in_func),
    .phase         (in_phase),
    .trigger_count (trigger_count),
    .state         (state),
    .state_next    (state_next),
    .direction     (dir_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase <= 2'd0;
      state.total <= 8'sd0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_dir <= dir_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {6'd0, out_dir};

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps

// Testbench for the quadrature detent decoder.
module tb;

  // Hard stop for the run, in clock cycles.
  localparam int CYCLE_LIMIT = 200000;
  // Length of the long receiver hold-off that backs the pipeline up.
  localparam int HOLD_CYCLES = 150;

  // One encoder sample as it travels on the input stream.
  typedef struct {
    logic resync;
    logic line_a;
    logic line_b;
  } sample_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;

  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'd0;   // [0] line_a, [1] line_b, [7:2] zero
  logic       s_tuser = 1'b0;   // [0] func (resync)

  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;          // [1:0] direction, [7:2] zero

  logic       cfg_we = 1'b0;
  logic [6:0] cfg_data = 7'd0;

  // Samples waiting to be offered, and detent events waiting to come out.
  sample_t        sample_queue[$];
  qdd_pkg::dir_t  detent_queue[$];

  int errors = 0;
  int cycle_count = 0;

  // Requests for a long hold-off are counted by the stimulus process and
  // served by the receiver, so each variable has a single writer.
  int hold_requests = 0;
  int hold_served = 0;

  quadrature_detent_decoder uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor. It keeps its own copy of the phase, the step accumulator and
  // the trigger setting. A step is classified by the position of each phase
  // along the clockwise Gray cycle 0 -> 2 -> 3 -> 1 -> 0: a distance of one
  // is a clockwise step, three is counter-clockwise, and two means both
  // lines moved at once.
  // ---------------------------------------------------------------------------
  logic [1:0] det_phase = 2'd0;
  int         det_total = 0;
  logic [6:0] det_trigger = qdd_pkg::TRIGGER_DEFAULT;
  int         gray_pos[4] = '{0, 3, 1, 2};

  function automatic qdd_pkg::dir_t decode_detent(logic resync, logic a, logic b);
    logic [1:0]    ph;
    int            gray_step;
    int            needed;
    int            mag;
    qdd_pkg::dir_t event_dir;
    ph = {a, b};
    event_dir = qdd_pkg::DIR_NONE;
    needed = (det_trigger == 7'd0) ? 4 : int'(det_trigger);
    if (resync) begin
      det_phase = ph;
      det_total = 0;
    end else if (ph != det_phase) begin
      gray_step = (gray_pos[ph] - gray_pos[det_phase] + 4) % 4;
      det_phase = ph;
      if (gray_step == 2) begin
        det_total = 0;
      end else begin
        // A step against the running direction starts the count over.
        if (gray_step == 1) begin
          if (det_total < 0) det_total = 0;
          det_total++;
        end else begin
          if (det_total > 0) det_total = 0;
          det_total--;
        end
        mag = (det_total < 0) ? -det_total : det_total;
        if (mag >= needed) begin
          event_dir = (det_total > 0) ? qdd_pkg::DIR_CW : qdd_pkg::DIR_CCW;
          det_total = 0;
        end
      end
    end
    return event_dir;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender. Words go out in bursts of random length separated by random gaps;
  // a gap of zero keeps the stream running back to back. The expected event
  // is computed the moment a word is taken.
  // ---------------------------------------------------------------------------
  int      burst_left = 0;
  int      gap_left = 0;
  sample_t next_sample;

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        detent_queue.push_back(decode_detent(s_tuser, s_tdata[0], s_tdata[1]));
      end
      if (!s_tvalid || s_tready) begin
        if (gap_left > 0 || sample_queue.size() == 0) begin
          s_tvalid <= 1'b0;
          if (gap_left > 0) gap_left--;
        end else begin
          next_sample = sample_queue.pop_front();
          s_tvalid <= 1'b1;
          s_tuser  <= next_sample.resync;
          s_tdata  <= {6'd0, next_sample.line_b, next_sample.line_a};
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver. The stall rate is redrawn periodically and can be zero, giving
  // stretches with no stalls at all. On request it holds off for a long stretch so
  // that the block fills and has to drop s_tready.
  // ---------------------------------------------------------------------------
  int            stall_pct = 0;
  int            hold_left = 0;
  qdd_pkg::dir_t want_dir;

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (detent_queue.size() == 0) begin
          $display("%0t: result word with none expected, expected none, actual 0x%02h",
                   $time, m_tdata);
          errors++;
        end else begin
          want_dir = detent_queue.pop_front();
          if (m_tdata !== {6'd0, want_dir}) begin
            $display("%0t: direction mismatch, expected 0x%02h, actual 0x%02h",
                     $time, {6'd0, want_dir}, m_tdata);
            errors++;
          end
        end
      end
      if (cycle_count % 50 == 0) begin
        case ($urandom_range(0, 3))
          0, 1: stall_pct = 0;
          2:    stall_pct = 30;
          default: stall_pct = 70;
        endcase
      end
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // Timeout watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus. The generator tracks the phase it has driven so that it can
  // produce well-formed Gray-code walks, mixed with repeated samples, double
  // transitions, resyncs and direction reversals.
  // ---------------------------------------------------------------------------
  logic [1:0] gen_phase = 2'd0;
  logic       gen_cw = 1'b1;
  logic [1:0] cw_next[4]  = '{2'd2, 2'd0, 2'd3, 2'd1};
  logic [1:0] ccw_next[4] = '{2'd1, 2'd3, 2'd0, 2'd2};

  task automatic add_sample(logic resync, logic [1:0] ph);
    sample_t s;
    s.resync = resync;
    s.line_a = ph[1];
    s.line_b = ph[0];
    sample_queue.push_back(s);
    gen_phase = ph;
  endtask

  // Random walk: flip_pct is the chance of reversing direction per step and
  // fault_pct the share of double transitions and resyncs.
  task automatic queue_walk(int count, int flip_pct, int fault_pct);
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < fault_pct / 3) begin
        add_sample(1'b1, 2'($urandom_range(0, 3)));
      end else if (r < fault_pct) begin
        add_sample(1'b0, gen_phase ^ 2'b11);
      end else if (r < fault_pct + 15) begin
        add_sample(1'b0, gen_phase);
      end else begin
        if ($urandom_range(0, 99) < flip_pct) gen_cw = !gen_cw;
        add_sample(1'b0, gen_cw ? cw_next[gen_phase] : ccw_next[gen_phase]);
      end
    end
  endtask

  // Register writes only happen once the block has nothing in flight. Every
  // word yields a result, so an empty expectation queue means it is idle.
  task automatic wait_idle();
    @(posedge clk);
    while (sample_queue.size() != 0 || s_tvalid || detent_queue.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_trigger(logic [6:0] value);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    det_trigger = value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  int         trig_plan[10] = '{0, 1, 2, 3, 6, 17, -1, -1, 64, 127};
  logic [6:0] trig_value;

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed part at the reset trigger of four.
    add_sample(1'b1, 2'd0);   // resync to phase 0
    add_sample(1'b0, 2'd0);   // unchanged phase
    add_sample(1'b0, 2'd2);   // four clockwise steps give a clockwise detent
    add_sample(1'b0, 2'd3);
    add_sample(1'b0, 2'd1);
    add_sample(1'b0, 2'd0);
    add_sample(1'b0, 2'd1);   // four counter-clockwise steps
    add_sample(1'b0, 2'd3);
    add_sample(1'b0, 2'd2);
    add_sample(1'b0, 2'd0);
    add_sample(1'b0, 2'd2);   // one step clockwise, then a reversal
    add_sample(1'b0, 2'd0);
    add_sample(1'b0, 2'd3);   // double transition clears the count
    add_sample(1'b1, 2'd3);   // resync with both lines high
    add_sample(1'b0, 2'd1);
    add_sample(1'b0, 2'd1);
    add_sample(1'b0, 2'd0);
    add_sample(1'b0, 2'd2);
    add_sample(1'b0, 2'd3);   // completes a detent after the resync

    foreach (trig_plan[p]) begin
      wait_idle();
      trig_value = (trig_plan[p] < 0) ? 7'($urandom_range(0, 127)) : 7'(trig_plan[p]);
      write_trigger(trig_value);
      // Large triggers need long runs in one direction to ever fire.
      if (trig_value >= 7'd64) queue_walk(180, 0, 0);
      else queue_walk(70, 10, 12);
      if (p == 3) hold_requests++;
    end

    wait_idle();
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
